>>> sv/lfr_pkg.sv
package lfr_pkg;

  // Default number of lamp ports.
  localparam int PORT_COUNT_DEF = 4;

  // Amount a current value moves toward its target on each tick.
  localparam int FADE_STEP = 1;

  // Percent full scale; targets above it are clamped.
  localparam logic [6:0] PCT_MAX = 7'd100;

  // Division by 100 as a multiply and shift. The products divided here stay
  // below 20001, where floor(x * 5243 / 2^19) equals floor(x / 100) exactly.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MUL_PROD,
    S_MUL_RECIP,
    S_COOL,
    S_WARM
  } state_t;

  typedef struct packed {
    logic       op;
    logic [2:0] port_number;
    logic [6:0] level_target;
    logic [6:0] warmth_target;
  } in_item_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [7:0] duty;
    logic       last;
  } out_item_t;

  // Clamp a 7-bit percent value to full scale.
  function automatic logic [6:0] clamp_pct(input logic [6:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

  // Move cur one fade step toward goal without overshooting it.
  function automatic logic [6:0] fade_step(input logic [6:0] cur, input logic [6:0] goal);
    logic [7:0] s;
    s = {1'b0, cur};
    if (cur < goal) begin
      s = {1'b0, cur} + 8'(FADE_STEP);
      if (s > {1'b0, goal}) s = {1'b0, goal};
    end else if (cur > goal) begin
      s = ({1'b0, cur} >= 8'(FADE_STEP)) ? {1'b0, cur} - 8'(FADE_STEP) : 8'd0;
      if (s < {1'b0, goal}) s = {1'b0, goal};
    end
    return s[6:0];
  endfunction

endpackage

>>> sv/lfr_in_if.sv
interface lfr_in_if;
  import lfr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/lfr_out_if.sv
interface lfr_out_if;
  import lfr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/lamp_fade_ramp_cct_mix.sv
// Channel   Direction  Transaction payload
// item      in         op, port_number, level_target, warmth_target
// result    out        channel, duty, last
//
// A set transaction is accepted in idle. A tick is accepted in idle, then the
// block walks the ports in order; every port that changed takes two passes
// through the shared multiplier, then gives its cool and warm results.
// No new item is accepted until the walk is done, and a result waits while
// the sink holds ready low.
// rst is synchronous: it clears all targets and current values to zero.
module lamp_fade_ramp_cct_mix #(
  parameter int PORT_COUNT = lfr_pkg::PORT_COUNT_DEF
) (
  input logic           clk,
  input logic           rst,
  lfr_in_if.sink        item,
  lfr_out_if.source     result
);
  import lfr_pkg::*;

  // Port index width; one bit even for a single port.
  localparam int IW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  // Per-port state. Small register arrays, read at the walk index and all compared for a tick.
  logic [6:0] goal_level  [PORT_COUNT];
  logic [6:0] goal_warmth [PORT_COUNT];
  logic [6:0] now_level   [PORT_COUNT];
  logic [6:0] now_warmth  [PORT_COUNT];

  state_t state, state_next;

  logic [IW-1:0]         idx;       // port being walked
  logic [PORT_COUNT-1:0] chg;       // ports that will change on this tick
  logic [PORT_COUNT-1:0] chg_now;   // compare of current against target
  logic [7:0]            t_reg;     // 2 * new brightness for the port
  logic [27:0]           mul_q;     // shared multiplier result
  logic [14:0]           mul_a;
  logic [12:0]           mul_b;
  logic [7:0]            warm_duty;
  logic                  idx_last;
  logic [IW+4:0]         ch_wide;
  logic                  set_ok;
  logic [IW-1:0]         set_idx;

  // Only ports 1..PORT_COUNT address a lamp; the index is zero based.
  assign set_ok  = (item.data.port_number != 3'd0) &&
                   (32'(item.data.port_number) <= PORT_COUNT);
  assign set_idx = IW'(item.data.port_number - 3'd1);

  assign idx_last  = (idx == IW'(PORT_COUNT - 1));
  assign warm_duty = mul_q[RECIP_SHIFT+7:RECIP_SHIFT];
  // Cool channel is 2*idx+1; the warm channel follows it.
  assign ch_wide   = {4'b0000, idx, 1'b0} + (IW+5)'(1);

  // A port changes on a tick when either current value differs from its target.
  always_comb begin
    for (int i = 0; i < PORT_COUNT; i++) begin
      chg_now[i] = (now_level[i] != goal_level[i]) || (now_warmth[i] != goal_warmth[i]);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item.valid && item.data.op == OP_TICK) state_next = S_WALK;
      end
      S_WALK: begin
        if (chg[idx]) state_next = S_MUL_PROD;
        else if (idx_last) state_next = S_IDLE;
      end
      S_MUL_PROD:  state_next = S_MUL_RECIP;
      S_MUL_RECIP: state_next = S_COOL;
      S_COOL: begin
        if (result.ready) state_next = S_WARM;
      end
      S_WARM: begin
        if (result.ready) state_next = idx_last ? S_IDLE : S_WALK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake, result payload and multiplier operand selection.
  always_comb begin
    item.ready          = 1'b0;
    result.valid        = 1'b0;
    result.data.channel = ch_wide[3:0];
    result.data.duty    = t_reg - warm_duty;
    result.data.last    = 1'b0;
    mul_a               = 15'(goal_warmth[idx]);
    mul_b               = 13'({now_level[idx], 1'b0});
    case (state)
      S_IDLE: item.ready = 1'b1;
      S_MUL_RECIP: begin
        // Second pass: scale the product by the reciprocal of 100.
        mul_a = mul_q[14:0];
        mul_b = RECIP_100;
      end
      S_COOL: result.valid = 1'b1;
      S_WARM: begin
        result.valid        = 1'b1;
        result.data.channel = 4'(ch_wide + (IW+5)'(1));
        result.data.duty    = warm_duty;
        // Final result of the tick when no later port still has work.
        result.data.last    = ((chg & ~(PORT_COUNT'(1) << idx)) == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      chg   <= '0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        goal_level[i]  <= '0;
        goal_warmth[i] <= '0;
        now_level[i]   <= '0;
        now_warmth[i]  <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            if (item.data.op == OP_TICK) begin
              idx <= '0;
              chg <= chg_now;
            end else if (set_ok) begin
              goal_level[set_idx]  <= clamp_pct(item.data.level_target);
              goal_warmth[set_idx] <= clamp_pct(item.data.warmth_target);
            end
          end
        end
        S_WALK: begin
          // Stepping an unchanged port leaves it as it is.
          now_level[idx]  <= fade_step(now_level[idx], goal_level[idx]);
          now_warmth[idx] <= fade_step(now_warmth[idx], goal_warmth[idx]);
          if (!chg[idx] && !idx_last) idx <= idx + IW'(1);
        end
        S_WARM: begin
          if (result.ready) begin
            chg[idx] <= 1'b0;
            if (!idx_last) idx <= idx + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Shared multiplier and brightness scale; payload only.
  always_ff @(posedge clk) begin
    if (state == S_MUL_PROD || state == S_MUL_RECIP) mul_q <= 28'(mul_a) * 28'(mul_b);
    if (state == S_MUL_PROD) t_reg <= {now_level[idx], 1'b0};
  end

`ifndef NO_ASSERTIONS
  // After the last result of a tick the walk only finishes its quiet ports.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.data.last) |=>
      (state == S_IDLE || state == S_WALK))
    else $error("walk continued after last result");

  // Duties never exceed twice full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.duty <= 8'd200))
    else $error("duty out of range");

  // A cool result is followed by the warm result of the same port.
  a_cool_warm: assert property (@(posedge clk) disable iff (rst)
    (state == S_COOL && result.ready) |=>
      (result.valid && result.data.channel == 4'($past(result.data.channel) + 4'd1)))
    else $error("warm result does not follow cool result");
`endif

endmodule

>>> verif/lamp_fade_ramp_cct_mix_tb.sv
`timescale 1ns / 100ps

module lamp_fade_ramp_cct_mix_tb;
  import lfr_pkg::*;

  // Number of lamp ports in the default build of the block.
  localparam int PORTS = PORT_COUNT_DEF;
  // Cycles allowed before the run is declared hung. The slowest correct run
  // is roughly 125 transactions, each with a sender gap, a walk and eight
  // results that each wait out a stall, so this limit is ample.
  localparam int CYCLE_LIMIT = 200000;
  // Quiet cycles after the last expected duty has arrived, enough for a tick
  // that moves every port.
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 100;

  // One entry of the stimulus queue. When hold is set, the entry carries no
  // transaction: the driver waits until every predicted duty has been seen.
  // When calm is set, the entry belongs to the final stretch of the run, and
  // neither side inserts idle cycles any more.
  typedef struct {
    logic     hold;
    logic     calm;
    in_item_t txn;
  } lamp_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfr_in_if  item_ch ();
  lfr_out_if result_ch ();

  lamp_fade_ramp_cct_mix u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source)
  );

  always #5 clk = ~clk;

  // Stimulus waiting to be driven, and the duty writes predicted but not yet seen.
  lamp_cmd_t lamp_cmds[$];
  out_item_t pending_duties[$];

  // The testbench's own copy of the lamp state: targets and current values.
  logic [6:0] aim_level  [PORTS];
  logic [6:0] aim_warmth [PORTS];
  logic [6:0] lit_level  [PORTS];
  logic [6:0] lit_warmth [PORTS];

  int faults = 0;
  int cycles = 0;
  logic calm_out = 1'b0;

  // Statistics for the closing summary.
  int n_ticks = 0;
  int n_silent_ticks = 0;
  int n_sets = 0;
  int n_ignored_sets = 0;
  int n_clamped = 0;
  int n_duties = 0;
  int peak_duty = 0;

  // Moves a current value one fade step toward its target. It stops on the
  // target and never overshoots it.
  function automatic logic [6:0] nudge(input logic [6:0] cur, input logic [6:0] goal);
    int c;
    int g;
    c = cur;
    g = goal;
    if (c < g) begin
      c = (c + FADE_STEP > g) ? g : c + FADE_STEP;
    end else if (c > g) begin
      c = (c - FADE_STEP < g) ? g : c - FADE_STEP;
    end
    return c[6:0];
  endfunction

  function automatic logic [6:0] limit_pct(input logic [6:0] v);
    if (v > PCT_MAX) begin
      n_clamped++;
      return PCT_MAX;
    end
    return v;
  endfunction

  // Applies one accepted transaction to the lamp state. A set updates the
  // targets of a port in the range 1 to PORTS and produces nothing. A tick
  // fades every port and queues a cool and a warm duty for each port that
  // moved. The warm share uses the port's target warmth and the new current
  // brightness, with truncating division by 100.
  task automatic apply_lamp_item(input in_item_t txn);
    int p;
    int first;
    int twice;
    int warm_d;
    logic [6:0] new_w;
    logic [6:0] new_b;
    out_item_t r;
    if (op_t'(txn.op) == OP_SET) begin
      n_sets++;
      if (txn.port_number >= 1 && txn.port_number <= PORTS) begin
        p = txn.port_number - 1;
        aim_level[p]  = limit_pct(txn.level_target);
        aim_warmth[p] = limit_pct(txn.warmth_target);
      end else begin
        n_ignored_sets++;
      end
    end else begin
      n_ticks++;
      first = pending_duties.size();
      for (p = 0; p < PORTS; p++) begin
        new_w = nudge(lit_warmth[p], aim_warmth[p]);
        new_b = nudge(lit_level[p], aim_level[p]);
        if (new_w != lit_warmth[p] || new_b != lit_level[p]) begin
          lit_warmth[p] = new_w;
          lit_level[p]  = new_b;
          twice  = 2 * new_b;
          warm_d = (aim_warmth[p] * twice) / 100;
          r.channel = 4'(2 * p + 1);
          r.duty    = 8'(twice - warm_d);
          r.last    = 1'b0;
          pending_duties.push_back(r);
          r.channel = 4'(2 * p + 2);
          r.duty    = 8'(warm_d);
          pending_duties.push_back(r);
        end
      end
      if (pending_duties.size() > first) begin
        pending_duties[pending_duties.size() - 1].last = 1'b1;
      end else begin
        n_silent_ticks++;
      end
    end
  endtask

  task automatic queue_cmd(input op_t op, input int port, input int lvl, input int warm,
                           input logic calm);
    lamp_cmd_t c;
    c.hold = 1'b0;
    c.calm = calm;
    c.txn.op = op;
    c.txn.port_number = 3'(port);
    c.txn.level_target = 7'(lvl);
    c.txn.warmth_target = 7'(warm);
    lamp_cmds.push_back(c);
  endtask

  task automatic queue_hold();
    lamp_cmd_t c;
    c.hold = 1'b1;
    c.calm = 1'b0;
    c.txn = '0;
    lamp_cmds.push_back(c);
  endtask

  // A percent target that mostly stays in range, favors low values so that
  // ports settle on their targets within the run, and sometimes exceeds 100.
  function automatic int pick_pct();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 40);
    if (r < 17) return $urandom_range(41, 100);
    return $urandom_range(101, 127);
  endfunction

  // The driver. Once a transaction has been offered, valid stays high until
  // it is accepted. Between transactions it inserts random idle bursts unless
  // the run is in its calm final stretch. A hold entry parks the sender until
  // the predicted duty queue has drained.
  int gap_left = 0;
  lamp_cmd_t head;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        apply_lamp_item(item_ch.data);
      end
      if (item_ch.valid && !item_ch.ready) begin
        // Still waiting for acceptance; keep offering the same transaction.
      end else if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (lamp_cmds.size() == 0) begin
        item_ch.valid <= 1'b0;
      end else if (lamp_cmds[0].hold) begin
        if (pending_duties.size() == 0) begin
          head = lamp_cmds.pop_front();
        end
        item_ch.valid <= 1'b0;
      end else if (!lamp_cmds[0].calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 18) - 1;
        item_ch.valid <= 1'b0;
      end else begin
        head = lamp_cmds.pop_front();
        calm_out = head.calm;
        item_ch.data  <= head.txn;
        item_ch.valid <= 1'b1;
      end
    end
  end

  // The monitor. It checks every accepted duty write against the oldest
  // prediction and lowers ready in random bursts of its own.
  int stall_left = 0;
  out_item_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        n_duties++;
        if (result_ch.data.duty > peak_duty) peak_duty = result_ch.data.duty;
        if (pending_duties.size() == 0) begin
          $error("unexpected duty write: channel %0d, duty %0d, last %0d",
                 result_ch.data.channel, result_ch.data.duty, result_ch.data.last);
          faults++;
        end else begin
          want = pending_duties.pop_front();
          if (result_ch.data.channel !== want.channel) begin
            $error("channel mismatch: expected %0d, got %0d", want.channel,
                   result_ch.data.channel);
            faults++;
          end
          if (result_ch.data.duty !== want.duty) begin
            $error("duty mismatch: expected %0d, got %0d", want.duty,
                   result_ch.data.duty);
            faults++;
          end
          if (result_ch.data.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last,
                   result_ch.data.last);
            faults++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (!calm_out && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that neither passes nor fails within the limit is hung.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    int port;
    logic calm;

    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    for (i = 0; i < PORTS; i++) begin
      aim_level[i] = '0;
      aim_warmth[i] = '0;
      lit_level[i] = '0;
      lit_warmth[i] = '0;
    end

    // Directed part. A tick straight after reset has nothing to do. Sets
    // addressed to port 0 or to a port above the last one must be dropped,
    // which the second silent tick confirms. Out-of-range targets are then
    // clamped to 100 on port 1, while the other ports get short ramps: one
    // settles after a few ticks, one changes only its warmth, and one lands
    // on a single step at full warmth. A hold lets every duty drain before
    // a ramp down to zero.
    queue_cmd(OP_TICK, 0, 127, 127, 1'b0);
    queue_cmd(OP_SET, 0, 100, 100, 1'b0);
    queue_cmd(OP_SET, 5, 100, 100, 1'b0);
    queue_cmd(OP_SET, 6, 127, 0, 1'b0);
    queue_cmd(OP_SET, 7, 0, 127, 1'b0);
    queue_cmd(OP_TICK, 7, 0, 0, 1'b0);
    queue_cmd(OP_SET, 1, 127, 127, 1'b0);
    queue_cmd(OP_SET, 2, 3, 0, 1'b0);
    queue_cmd(OP_SET, 3, 0, 2, 1'b0);
    queue_cmd(OP_SET, 4, 1, 100, 1'b0);
    repeat (4) queue_cmd(OP_TICK, 2, 85, 42, 1'b0);
    queue_hold();
    queue_cmd(OP_SET, 2, 0, 0, 1'b0);
    queue_cmd(OP_SET, 3, 100, 101, 1'b0);
    repeat (3) queue_cmd(OP_TICK, 5, 21, 106, 1'b0);
    queue_cmd(OP_SET, 1, 0, 0, 1'b0);
    queue_cmd(OP_SET, 4, 100, 0, 1'b0);
    repeat (2) queue_cmd(OP_TICK, 0, 0, 0, 1'b0);

    // Random part. Most transactions are ticks, so ports really reach their
    // targets and fall silent; sets mostly address real ports, with a few
    // addressed to ports that do not exist. The payload of a tick is ignored
    // by the block, so it is random over its whole width. The last stretch
    // runs without idle cycles, and a hold sits in the middle of the run.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= RANDOM_ITEMS - 20);
      if (i == RANDOM_ITEMS / 2) queue_hold();
      if ($urandom_range(0, 9) < 7) begin
        queue_cmd(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 127),
                  $urandom_range(0, 127), calm);
      end else begin
        if ($urandom_range(0, 6) == 0) begin
          port = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(PORTS + 1, 7);
        end else begin
          port = $urandom_range(1, PORTS);
        end
        queue_cmd(OP_SET, port, pick_pct(), pick_pct(), calm);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait until every transaction has been accepted and every predicted
    // duty has been seen, then leave room for any stray result.
    @(posedge clk);
    while (lamp_cmds.size() != 0 || item_ch.valid === 1'b1 || pending_duties.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    // Anything still outstanding at this point never reached the result side.
    if (lamp_cmds.size() != 0 || pending_duties.size() != 0) begin
      $error("run ended with %0d transactions unsent and %0d duty writes missing",
             lamp_cmds.size(), pending_duties.size());
      faults++;
    end

    $display("Covered %0d ticks (%0d silent) and %0d sets (%0d ignored, %0d clamped fields).",
             n_ticks, n_silent_ticks, n_sets, n_ignored_sets, n_clamped);
    $display("Checked %0d duty writes, highest duty %0d, in %0d cycles.",
             n_duties, peak_duty, cycles);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lfr_pkg.sv
sv/lfr_in_if.sv
sv/lfr_out_if.sv
sv/lamp_fade_ramp_cct_mix.sv
verif/lamp_fade_ramp_cct_mix_tb.sv
